// ===== hw/rtl/erta_pkg.sv =====
// erta_pkg: shared types and constants for the echo range trimmed average block
package erta_pkg;

  // item commands
  typedef enum logic [1:0] {
    CMD_RISE  = 2'd0,
    CMD_FALL  = 2'd1,
    CMD_START = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BUSY     = 2'd1,
    STAT_NO_BURST = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_STATS,
    S_TRIM,
    S_AVG,
    S_SCALE,
    S_CM,
    S_FINISH
  } state_t;

  localparam logic [7:0] SAMPLES_RESET = 8'd3;
  localparam logic [7:0] SAMPLES_MIN   = 8'd3;
  localparam logic [7:0] SAMPLES_MAX   = 8'd254;

  // mean * 340 / 80000 / 100 == ((mean * 17) >> 7) / 3125 with truncation
  // smallest mean whose distance no longer fits in 10 bits
  localparam logic [63:0] CM_SAT_MEAN    = 64'd24094118;
  // ceil(2^34 / 3125), exact for every dividend below the saturation point
  localparam logic [22:0] CM_RECIP       = 23'd5497559;
  localparam int          CM_RECIP_SHIFT = 34;

  localparam logic [9:0] DIST_MAX = 10'd1023;

endpackage

// ===== hw/rtl/echo_range_trimmed_average_top.sv =====
// echo_range_trimmed_average_top: echo width capture, trimmed mean and distance ring fifo
//
// usage
//   input channel (in_valid/in_ready): one command per transfer; rising and falling
//   echo edges carry a timestamp, start opens a burst (optionally clearing the fifo),
//   read returns one fifo slot chosen by read_index
//   output channel (out_valid/out_ready): exactly one result per input transfer, in order
//   config channel (cfg_valid/cfg_ready): writes samples_m, always ready, write while idle
// timing
//   one item at a time; in_ready is high only while the sequencer is idle
//   rise, start and read items go from decode straight to the result; a falling edge
//   that does not end the burst first updates the width statistics
//   the falling edge that ends a burst runs the serial divider once (trimmed sum /
//   clamped samples_m, one quotient bit per cycle), then scales by a reciprocal multiply
// reset
//   synchronous rst clears the sequencer, burst state, fifo valid bits and pointers,
//   and sets samples_m to 3; fifo storage itself is not cleared, invalid slots read 0
// stall
//   a finished result sits in the output register; if out_ready is low the
//   sequencer holds in its last state and in_ready stays low until it is taken
module echo_range_trimmed_average_top #(
  parameter int FIFO_DEPTH = 8,
  parameter int WIDTH_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [63:0] timestamp,
  input  logic        clear_buffer,
  input  logic [2:0]  read_index,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [9:0]  distance_cm,
  output logic [63:0] entry_timestamp,
  output logic [3:0]  fifo_count,
  output logic        new_average,
  output logic        burst_active,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  samples_m
);

  import erta_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  // up to 256 widths summed
  localparam int SUM_W = WIDTH_BITS + 8;

  // sequencer
  state_t state, state_next;

  // latched item
  cmd_t        cmd;
  logic [63:0] ts;
  logic        clr;
  logic [2:0]  idx;

  // config
  logic [7:0] m_cfg;
  logic [7:0] m_eff;

  // burst state
  logic [63:0]           echo_start;
  logic [7:0]            sample_count;
  logic                  burst_running;
  logic [WIDTH_BITS-1:0] width_min;
  logic [WIDTH_BITS-1:0] width_max;
  logic [WIDTH_BITS-1:0] width_cur;
  logic [SUM_W-1:0]      width_sum;
  logic [SUM_W-1:0]      avg;

  // ring fifo
  logic [9:0]            fifo_dist_mem [FIFO_DEPTH];
  logic [63:0]           fifo_time_mem [FIFO_DEPTH];
  logic [FIFO_DEPTH-1:0] slot_valid;
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      wr_ptr_next;
  logic [PTR_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      entry_count;
  logic [9:0]            rd_dist;
  logic [63:0]           rd_time;
  logic                  rd_hit;
  logic                  idx_in_range;

  // per-item results
  status_t     res_status;
  logic [9:0]  res_dist;
  logic [63:0] res_time;
  logic        res_fresh;

  // datapath
  logic [63:0]           raw_width;
  logic [WIDTH_BITS-1:0] width_sat;
  logic [WIDTH_BITS-1:0] min_next;
  logic [WIDTH_BITS-1:0] max_next;
  logic [SUM_W-1:0]      sum_next;
  logic [7:0]            count_next;
  logic                  burst_done;
  logic [SUM_W-1:0]      trimmed;
  logic [63:0]           avg_wide;
  logic [29:0]           avg_x17;
  logic [21:0]           scale_y;
  logic                  scale_sat;
  logic [44:0]           cm_prod;
  logic [9:0]            cm_sat;

  // serial divider
  logic             div_start;
  logic [SUM_W-1:0] div_dividend;
  logic [7:0]       div_divisor;
  logic             div_busy;
  logic             div_done;
  logic [SUM_W-1:0] div_quotient;
  logic             out_load;

  erta_div #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (8)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // ---------------------------------------------------------------------------
  // configuration register, always ready
  // ---------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_cfg <= SAMPLES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      m_cfg <= samples_m;
    end
  end

  // clamp to the supported sample range
  always_comb begin
    if (m_cfg < SAMPLES_MIN) begin
      m_eff = SAMPLES_MIN;
    end else if (m_cfg > SAMPLES_MAX) begin
      m_eff = SAMPLES_MAX;
    end else begin
      m_eff = m_cfg;
    end
  end

  // ---------------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------------
  // echo width saturated to the width field
  assign raw_width = ts - echo_start;
  assign width_sat = (|raw_width[63:WIDTH_BITS]) ? '1 : raw_width[WIDTH_BITS-1:0];

  assign min_next   = (width_cur < width_min) ? width_cur : width_min;
  assign max_next   = (width_cur > width_max) ? width_cur : width_max;
  assign sum_next   = width_sum + SUM_W'(width_cur);
  assign count_next = sample_count + 8'd1;
  // count wrapping to zero also ends the burst
  assign burst_done = ({1'b0, count_next} >= ({1'b0, m_eff} + 9'd2)) || (count_next == 8'd0);

  // drop min and max before the mean
  assign trimmed      = width_sum - SUM_W'(width_max) - SUM_W'(width_min);
  assign div_dividend = trimmed;
  assign div_divisor  = m_eff;

  // below the saturation point the mean fits in 25 bits
  assign avg_wide = 64'(avg);
  assign avg_x17  = {1'b0, avg_wide[24:0], 4'd0} + {5'd0, avg_wide[24:0]};
  // divide by 3125 through the reciprocal
  assign cm_prod  = 45'(scale_y) * 45'(CM_RECIP);
  assign cm_sat   = scale_sat ? DIST_MAX : cm_prod[CM_RECIP_SHIFT+9:CM_RECIP_SHIFT];

  assign idx_in_range = int'(idx) < FIFO_DEPTH;
  assign rd_addr      = PTR_W'(idx);
  assign wr_ptr_next  = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (cmd == CMD_FALL && burst_running) state_next = S_STATS;
        else state_next = S_FINISH;
      end
      S_STATS: begin
        state_next = burst_done ? S_TRIM : S_FINISH;
      end
      S_TRIM: begin
        state_next = S_AVG;
      end
      S_AVG: begin
        if (div_done) state_next = S_SCALE;
      end
      S_SCALE: begin
        state_next = S_CM;
      end
      S_CM: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_TRIM: begin
        div_start = 1'b1;
      end
      S_FINISH: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // item latch
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_t'(command);
      ts  <= timestamp;
      clr <= clear_buffer;
      idx <= read_index;
    end
  end

  // ---------------------------------------------------------------------------
  // burst and fifo control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_start    <= '0;
      sample_count  <= '0;
      burst_running <= 1'b0;
      width_min     <= '1;
      width_max     <= '0;
      width_sum     <= '0;
      wr_ptr        <= '0;
      entry_count   <= '0;
      slot_valid    <= '0;
    end else begin
      case (state)
        S_DECODE: begin
          case (cmd)
            CMD_RISE: begin
              if (burst_running) echo_start <= ts;
            end
            CMD_START: begin
              // a clear applies even when the start itself is rejected
              if (clr) begin
                slot_valid  <= '0;
                wr_ptr      <= '0;
                entry_count <= '0;
              end
              if (!burst_running) begin
                burst_running <= 1'b1;
                sample_count  <= '0;
                width_min     <= '1;
                width_max     <= '0;
                width_sum     <= '0;
              end
            end
            default: begin
            end
          endcase
        end
        S_STATS: begin
          width_min    <= min_next;
          width_max    <= max_next;
          width_sum    <= sum_next;
          sample_count <= count_next;
        end
        S_CM: begin
          // push overwrites the oldest slot once full
          slot_valid[wr_ptr] <= 1'b1;
          wr_ptr             <= wr_ptr_next;
          if (entry_count != CNT_W'(FIFO_DEPTH)) entry_count <= entry_count + CNT_W'(1);
          sample_count  <= '0;
          burst_running <= 1'b0;
          width_min     <= '1;
          width_max     <= '0;
          width_sum     <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state)
      S_DECODE: begin
        width_cur <= width_sat;
        res_dist  <= '0;
        res_time  <= '0;
        res_fresh <= 1'b0;
        if ((cmd == CMD_RISE || cmd == CMD_FALL) && !burst_running) begin
          res_status <= STAT_NO_BURST;
        end else if (cmd == CMD_START && burst_running) begin
          res_status <= STAT_BUSY;
        end else begin
          res_status <= STAT_OK;
        end
      end
      S_AVG: begin
        if (div_done) avg <= div_quotient;
      end
      S_SCALE: begin
        // mean * 17 >> 7, and the overflow flag for the 10-bit distance
        scale_y   <= avg_x17[28:7];
        scale_sat <= (avg_wide >= CM_SAT_MEAN);
      end
      S_CM: begin
        res_dist  <= cm_sat;
        res_time  <= ts;
        res_fresh <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // fifo storage, one write port at the write pointer, registered read
  always_ff @(posedge clk) begin
    if (state == S_CM) begin
      fifo_dist_mem[wr_ptr] <= cm_sat;
      fifo_time_mem[wr_ptr] <= ts;
    end
    rd_dist <= fifo_dist_mem[rd_addr];
    rd_time <= fifo_time_mem[rd_addr];
    rd_hit  <= idx_in_range && slot_valid[rd_addr];
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      fifo_count   <= 4'(entry_count);
      new_average  <= res_fresh;
      burst_active <= burst_running;
      if (cmd == CMD_READ) begin
        distance_cm     <= rd_hit ? rd_dist : '0;
        entry_timestamp <= rd_hit ? rd_time : '0;
      end else begin
        distance_cm     <= res_dist;
        entry_timestamp <= res_time;
      end
    end
  end

`ifndef ASSERT_OFF
  a_div_running: assert property (@(posedge clk) disable iff (rst)
    (state == S_AVG) |-> (div_busy || div_done))
    else $error("waiting on divider that is not running");
  a_valid_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(entry_count))
    else $error("fifo valid bits disagree with entry count");
  a_idle_no_samples: assert property (@(posedge clk) disable iff (rst)
    !burst_running |-> sample_count == 8'd0)
    else $error("samples counted outside a burst");
  a_new_avg_ends_burst: assert property (@(posedge clk) disable iff (rst)
    (out_valid && new_average) |-> !burst_active)
    else $error("new average reported while burst still active");
`endif

endmodule

// ===== hw/rtl/erta_div.sv =====
// erta_div: restoring serial divider, one quotient bit per cycle
module erta_div #(
  parameter int DIVIDEND_W = 41,
  parameter int DIVISOR_W  = 23
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvsr;
  logic [CNT_W-1:0]      cnt;
  logic [DIVISOR_W:0]    shifted;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  assign shifted  = {rem, quo[DIVIDEND_W-1]};
  assign diff     = shifted - {1'b0, dvsr};
  assign fits     = ~diff[DIVISOR_W];
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo  <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quo <= {quo[DIVIDEND_W-2:0], fits};
      rem <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

`ifndef ASSERT_OFF
  a_start_when_free: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> (!busy && $past(busy)))
    else $error("divider done without a running division");
  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> cnt != '0)
    else $error("divider busy with empty count");
`endif

endmodule

// ===== tb/tb_echo_range_trimmed_average_top.sv =====
// self-checking testbench for the echo range trimmed average block: directed table, then random phases
module tb_echo_range_trimmed_average_top;
  import erta_pkg::*;

  // run shape
  localparam int RANDOM_ITEMS   = 1950;
  localparam int QUIET_ITEMS    = 150;   // closing stretch with no idling at all
  localparam int SQUEEZE_AFTER  = 300;   // results taken before the long receiver hold-off
  localparam int SQUEEZE_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 120;   // longer than a burst-ending fall
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on any channel

  // echo width cap and distance scaling: ((mean * 340) / 80000) / 100
  localparam logic [63:0] WIDTH_CAP   = 64'h0000_0000_00FF_FFFF;
  localparam logic [63:0] SOUND_SPEED = 64'd340;
  localparam logic [63:0] STAMP_DIV   = 64'd80000;
  localparam logic [63:0] CM_DIV      = 64'd100;

  typedef struct packed {
    status_t     status;
    logic [9:0]  cm;
    logic [63:0] stamp;
    logic [3:0]  count;
    logic        fresh;
    logic        busy;
  } range_result_t;

  // one row of the directed table: either a register write or an item
  typedef struct packed {
    logic          is_cfg;
    logic [7:0]    setting;
    cmd_t          cmd;
    logic [63:0]   stamp;
    logic          clr;
    logic [2:0]    slot;
    logic          typed;   // want holds a hand-written result
    range_result_t want;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = 2'd0;
  logic [63:0] timestamp = 64'd0;
  logic        clear_buffer = 1'b0;
  logic [2:0]  read_index = 3'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [9:0]  distance_cm;
  logic [63:0] entry_timestamp;
  logic [3:0]  fifo_count;
  logic        new_average;
  logic        burst_active;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  samples_m = SAMPLES_RESET;

  echo_range_trimmed_average_top dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .timestamp       (timestamp),
    .clear_buffer    (clear_buffer),
    .read_index      (read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .distance_cm     (distance_cm),
    .entry_timestamp (entry_timestamp),
    .fifo_count      (fifo_count),
    .new_average     (new_average),
    .burst_active    (burst_active),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .samples_m       (samples_m)
  );

  always #5 clk = ~clk;

  // shared run state
  range_result_t range_due[$];   // results owed by the block, oldest first
  plan_row_t     test_plan[$];
  int            errors = 0;
  int            items_sent = 0;
  int            bursts_done = 0;
  int            results_seen = 0;
  int            stuck = 0;
  bit            quiet = 1'b0;   // no idling on either side while set
  logic [63:0]   now = 64'd1000; // free-running echo clock for well-formed pairs

  // own copy of the block state
  logic [7:0]  m_setting;
  logic [63:0] rise_stamp;
  logic [7:0]  n_widths;
  logic        burst_on;
  logic [23:0] w_lo;
  logic [23:0] w_hi;
  logic [32:0] w_total;
  logic [9:0]  ring_cm [8];
  logic [63:0] ring_stamp [8];
  logic [2:0]  ring_wr;
  logic [3:0]  ring_fill;

  function automatic void clear_width_stats();
    w_lo = '1;
    w_hi = '0;
    w_total = '0;
  endfunction

  function automatic void empty_ring();
    for (int i = 0; i < 8; i++) begin
      ring_cm[i] = '0;
      ring_stamp[i] = '0;
    end
    ring_wr = '0;
    ring_fill = '0;
  endfunction

  function automatic void clear_range_state();
    m_setting = SAMPLES_RESET;
    rise_stamp = '0;
    n_widths = '0;
    burst_on = 1'b0;
    clear_width_stats();
    empty_ring();
  endfunction

  // result of one item, advancing the state copy
  function automatic range_result_t compute_range_result(cmd_t c, logic [63:0] stamp,
                                                         logic clr, logic [2:0] slot);
    range_result_t r;
    logic [63:0] w;
    logic [63:0] m;
    logic [63:0] mean;
    logic [63:0] cm;
    r = '0;
    r.status = STAT_OK;
    case (c)
      CMD_RISE: begin
        if (burst_on) rise_stamp = stamp;
        else r.status = STAT_NO_BURST;
      end
      CMD_FALL: begin
        if (!burst_on) begin
          r.status = STAT_NO_BURST;
        end else begin
          // width wraps modulo 2^64, then saturates
          w = stamp - rise_stamp;
          if (w > WIDTH_CAP) w = WIDTH_CAP;
          // samples setting outside 3..254 is clamped, read at every fall
          if (m_setting < SAMPLES_MIN) m = 64'(SAMPLES_MIN);
          else if (m_setting > SAMPLES_MAX) m = 64'(SAMPLES_MAX);
          else m = 64'(m_setting);
          if (w[23:0] < w_lo) w_lo = w[23:0];
          if (w[23:0] > w_hi) w_hi = w[23:0];
          w_total = w_total + 33'(w[23:0]);
          n_widths = n_widths + 8'd1;
          // count may already be past target if the setting was lowered mid-burst;
          // an 8-bit wrap to zero also ends the burst
          if (64'(n_widths) >= m + 64'd2 || n_widths == 8'd0) begin
            mean = (64'(w_total) - 64'(w_hi) - 64'(w_lo)) / m;
            cm = ((mean * SOUND_SPEED) / STAMP_DIV) / CM_DIV;
            if (cm > 64'(DIST_MAX)) cm = 64'(DIST_MAX);
            ring_cm[ring_wr] = cm[9:0];
            ring_stamp[ring_wr] = stamp;
            ring_wr = ring_wr + 3'd1;
            if (ring_fill < 4'd8) ring_fill = ring_fill + 4'd1;
            r.cm = cm[9:0];
            r.stamp = stamp;
            r.fresh = 1'b1;
            n_widths = '0;
            burst_on = 1'b0;
            clear_width_stats();
          end
        end
      end
      CMD_START: begin
        // the ring is emptied even when the start is refused
        if (clr) empty_ring();
        if (burst_on) begin
          r.status = STAT_BUSY;
        end else begin
          burst_on = 1'b1;
          n_widths = '0;
          clear_width_stats();
        end
      end
      CMD_READ: begin
        r.cm = ring_cm[slot];
        r.stamp = ring_stamp[slot];
      end
      default: begin
      end
    endcase
    r.count = ring_fill;
    r.busy = burst_on;
    return r;
  endfunction

  // directed table builders
  function automatic void item_row(cmd_t c, logic [63:0] stamp, logic clr, logic [2:0] slot);
    plan_row_t r;
    r = '0;
    r.cmd = c;
    r.stamp = stamp;
    r.clr = clr;
    r.slot = slot;
    test_plan.push_back(r);
  endfunction

  function automatic void known_row(cmd_t c, logic [63:0] stamp, logic clr, logic [2:0] slot,
                                    status_t st, logic [3:0] fill, logic busy);
    plan_row_t r;
    r = '0;
    r.cmd = c;
    r.stamp = stamp;
    r.clr = clr;
    r.slot = slot;
    r.typed = 1'b1;
    r.want.status = st;
    r.want.count = fill;
    r.want.busy = busy;
    test_plan.push_back(r);
  endfunction

  function automatic void cfg_row(logic [7:0] setting);
    plan_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.setting = setting;
    test_plan.push_back(r);
  endfunction

  // one input transfer, with an optional idle burst in front of it
  task automatic drive_item(cmd_t c, logic [63:0] stamp, logic clr, logic [2:0] slot,
                            bit typed, range_result_t want);
    range_result_t predicted;
    int gap;
    gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    timestamp <= stamp;
    clear_buffer <= clr;
    read_index <= slot;
    do @(posedge clk); while (!in_ready);
    predicted = compute_range_result(c, stamp, clr, slot);
    range_due.push_back(typed ? want : predicted);
    if (predicted.fresh) bursts_done++;
    items_sent++;
  endtask

  // random-part item: the fields the command ignores still toggle
  task automatic offer(cmd_t c, logic [63:0] stamp, logic clr);
    drive_item(c, stamp, clr, 3'($urandom_range(0, 7)), 1'b0, '0);
  endtask

  // drop valid and wait until every owed result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (range_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_samples(logic [7:0] setting);
    @(negedge clk);
    cfg_valid <= 1'b1;
    samples_m <= setting;
    do @(posedge clk); while (!cfg_ready);
    m_setting = setting;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // well-formed echo: rising edge then falling edge after a random width
  task automatic echo_pair();
    logic [63:0] w;
    case ($urandom_range(0, 9))
      0: w = 64'($urandom_range(0, 1000));
      1: w = 64'h00FF_FFFE + 64'($urandom_range(0, 3));   // around the saturation point
      2: w = {32'd0, $urandom};
      default: w = 64'($urandom_range(0, 24'hFF_FFFF));
    endcase
    // occasional jump so every counter bit moves, wraps included
    if ($urandom_range(0, 19) == 0) now = {$urandom, $urandom};
    offer(CMD_RISE, now, 1'($urandom_range(0, 1)));
    offer(CMD_FALL, now + w, 1'($urandom_range(0, 1)));
    now = now + w + 64'($urandom_range(1, 5000));
  endtask

  // one configuration setting, then a mix of bursts, reads and noise
  task automatic run_phase(logic [7:0] setting, int quota, bit to_completion);
    int stop_at;
    int done_before;
    int k;
    wait_drained();
    write_samples(setting);
    stop_at = items_sent + quota;
    done_before = bursts_done;
    while (items_sent < stop_at || (to_completion && bursts_done == done_before)) begin
      k = $urandom_range(0, 99);
      if (k < 72) begin
        if (burst_on) echo_pair();
        else offer(CMD_START, now, $urandom_range(0, 3) == 0);
      end else if (k < 80) begin
        offer(CMD_READ, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end else if (k < 86) begin
        // stray start, refused while a burst runs
        offer(CMD_START, now, $urandom_range(0, 3) == 0);
      end else if (k < 93) begin
        // lone edge: broken sequence
        offer($urandom_range(0, 1) ? CMD_FALL : CMD_RISE,
              now + 64'($urandom_range(0, 3000000)), 1'($urandom_range(0, 1)));
      end else begin
        offer(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // every result transfer is matched against the oldest owed result
  always @(posedge clk) begin : result_check
    range_result_t want;
    if (out_valid && out_ready) begin
      results_seen++;
      if (range_due.size() == 0) begin
        $error("result transfer with no item outstanding");
        errors++;
      end else begin
        want = range_due.pop_front();
        check_field("status", 64'(want.status), 64'(status));
        check_field("distance_cm", 64'(want.cm), 64'(distance_cm));
        check_field("entry_timestamp", want.stamp, entry_timestamp);
        check_field("fifo_count", 64'(want.count), 64'(fifo_count));
        check_field("new_average", 64'(want.fresh), 64'(new_average));
        check_field("burst_active", 64'(want.busy), 64'(burst_active));
      end
    end
  end

  // receiver: random stalls, one long hold-off so the block backs up into the sender
  initial begin : receiver
    int rx_wait;
    bit squeezed;
    rx_wait = 0;
    squeezed = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_wait == 0) begin
        if (!squeezed && results_seen >= SQUEEZE_AFTER) begin
          rx_wait = SQUEEZE_CYCLES;
          squeezed = 1'b1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          rx_wait = $urandom_range(1, 13);
        end
      end
      if (rx_wait > 0) begin
        out_ready <= 1'b0;
        rx_wait--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stuck = 0;
    end else begin
      stuck++;
    end
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("tb_echo_range_trimmed_average_top: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int random_end;
    int k;
    logic [7:0] setting;
    clear_range_state();

    // directed table
    // edges with no burst, read after reset
    known_row(CMD_RISE, 64'd0, 1'b0, 3'd0, STAT_NO_BURST, 4'd0, 1'b0);
    known_row(CMD_FALL, '1, 1'b1, 3'd7, STAT_NO_BURST, 4'd0, 1'b0);
    known_row(CMD_READ, '1, 1'b1, 3'd7, STAT_OK, 4'd0, 1'b0);
    // start, then start while busy
    known_row(CMD_START, 64'd0, 1'b1, 3'd0, STAT_OK, 4'd0, 1'b1);
    known_row(CMD_START, 64'd0, 1'b0, 3'd0, STAT_BUSY, 4'd0, 1'b1);
    // five widths at the reset setting: saturated, zero, no rise, wrapped, plain
    item_row(CMD_RISE, 64'd0, 1'b0, 3'd0);
    item_row(CMD_FALL, '1, 1'b0, 3'd0);
    item_row(CMD_RISE, 64'd12345, 1'b1, 3'd5);
    item_row(CMD_FALL, 64'd12345, 1'b0, 3'd2);
    item_row(CMD_FALL, 64'd2000000, 1'b0, 3'd0);
    item_row(CMD_RISE, 64'hFFFF_FFFF_FFFF_FC18, 1'b0, 3'd0);
    item_row(CMD_FALL, 64'd500000, 1'b0, 3'd0);
    item_row(CMD_RISE, 64'd7, 1'b0, 3'd0);
    item_row(CMD_FALL, 64'd5000007, 1'b0, 3'd0);
    item_row(CMD_READ, 64'd0, 1'b0, 3'd0);
    // burst at the top setting, five widths, fifo cleared by a refused start
    cfg_row(8'd254);
    item_row(CMD_START, 64'd0, 1'b0, 3'd0);
    for (k = 0; k < 5; k++) item_row(CMD_FALL, 64'd6000000 + 64'(k) * 64'd1000000, 1'b0, 3'd3);
    known_row(CMD_START, 64'd0, 1'b1, 3'd0, STAT_BUSY, 4'd0, 1'b1);
    // setting below range, count already at target: next fall ends the burst
    cfg_row(8'd2);
    item_row(CMD_FALL, 64'd11000000, 1'b0, 3'd0);
    item_row(CMD_READ, 64'd0, 1'b0, 3'd0);
    item_row(CMD_READ, 64'd0, 1'b1, 3'd7);

    // reset once, released on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (test_plan[i]) begin
      if (test_plan[i].is_cfg) begin
        wait_drained();
        write_samples(test_plan[i].setting);
      end else begin
        drive_item(test_plan[i].cmd, test_plan[i].stamp, test_plan[i].clr, test_plan[i].slot,
                   test_plan[i].typed, test_plan[i].want);
      end
    end

    // random phases: register extremes first, one burst at the largest size
    random_end = items_sent + RANDOM_ITEMS - QUIET_ITEMS;
    run_phase(8'd255, 0, 1'b1);
    run_phase(8'd254, 40, 1'b0);   // left mid-burst on purpose
    run_phase(8'd3, 150, 1'b0);
    run_phase(8'd0, 100, 1'b0);
    while (items_sent < random_end) begin
      k = $urandom_range(0, 19);
      if (k < 14) setting = 8'($urandom_range(3, 8));
      else if (k < 16) setting = 8'($urandom_range(0, 2));
      else if (k < 19) setting = 8'($urandom_range(9, 40));
      else setting = 8'($urandom_range(200, 255));
      quiet = ($urandom_range(0, 4) == 0);
      run_phase(setting, $urandom_range(60, 200), 1'b0);
    end
    // closing stretch at full rate on both sides
    quiet = 1'b1;
    run_phase(8'd4, QUIET_ITEMS, 1'b0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tb_echo_range_trimmed_average_top: clean");
    end else begin
      $display("tb_echo_range_trimmed_average_top: errors");
    end
    $finish;
  end

endmodule
